>>> hdl/dsno_pkg.sv
// ----------------------------------------------------------------------------
// dsno_pkg
// Shared constants, types and helpers for the daily schedule next-occurrence
// block.
// ----------------------------------------------------------------------------
package dsno_pkg;

    localparam int MAX_ENTRIES_DEF = 32;

    localparam int SEC_W = 17;   // second of day
    localparam int MIN_W = 14;   // signed start minute
    localparam int DUR_W = 11;   // duration in minutes
    localparam int FUNC_W = 2;

    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic [SEC_W-1:0] SEC_PER_DAY = 17'd86400;
    localparam logic [14:0] MIN_PER_DAY = 15'd1440;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Table write commands issued by the control side
    typedef struct packed {
        logic             clr;
        logic             wr;
        logic [SEC_W-1:0] wr_second;
    } t_tbl_cmd;

    // Signed minute -> second of day. Bias into positive range, then
    // reduce modulo one day with four binary compare/subtract steps.
    function automatic logic [SEC_W-1:0] minute_to_second(input logic [MIN_W-1:0] m);
        logic signed [15:0] biased;
        logic [14:0]        x;
        logic [10:0]        r;
        biased = $signed({{2{m[MIN_W-1]}}, m}) + 16'sd8640;
        x = biased[14:0];
        if (x >= 15'(MIN_PER_DAY * 8)) x = x - 15'(MIN_PER_DAY * 8);
        if (x >= 15'(MIN_PER_DAY * 4)) x = x - 15'(MIN_PER_DAY * 4);
        if (x >= 15'(MIN_PER_DAY * 2)) x = x - 15'(MIN_PER_DAY * 2);
        if (x >= MIN_PER_DAY) x = x - MIN_PER_DAY;
        r = x[10:0];
        return {r, 6'b0} - {4'b0, r, 2'b0};
    endfunction

    // Duration in minutes -> seconds (x60)
    function automatic logic [SEC_W-1:0] minutes_to_seconds(input logic [DUR_W-1:0] d);
        return {d, 6'b0} - {4'b0, d, 2'b0};
    endfunction

endpackage

>>> hdl/dsno_table.sv
// ----------------------------------------------------------------------------
// dsno_table
// Start-time memory with fill count: clear, append at the fill point and one
// registered read port.
// ----------------------------------------------------------------------------
module dsno_table #(
    parameter int MAX_ENTRIES = dsno_pkg::MAX_ENTRIES_DEF,
    parameter int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    parameter int CW = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dsno_pkg::t_tbl_cmd         i_cmd,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [dsno_pkg::SEC_W-1:0] o_rd_data,
    output logic [CW-1:0]              o_count
);

    logic [dsno_pkg::SEC_W-1:0] r_mem [MAX_ENTRIES];
    logic [dsno_pkg::SEC_W-1:0] r_rd_data;
    logic [CW-1:0]              r_count;
    logic                       w_room;

    assign w_room = (r_count < CW'(MAX_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clr) begin
            r_count <= '0;
        end else if (i_cmd.wr && w_room) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Appends past the last slot are dropped
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_room) begin
            r_mem[r_count[AW-1:0]] <= i_cmd.wr_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

>>> hdl/daily_schedule_next_occurrence_top.sv
// ----------------------------------------------------------------------------
// daily_schedule_next_occurrence_top
// Table of daily start times; a query reports the running or next entry.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries commands: clear table, append a start minute, or
//   query at a second of the day. Clear and append give no result. A query
//   walks the stored entries in load order, one memory read per cycle, and
//   returns one result transaction on the master stream. It passes a fetch
//   state, scans the entries and then loads the output register; the scan
//   stops early when an entry's window covers the query second. An empty
//   table goes straight to loading the output register. The single read
//   port of the start memory sets the pace; one item is worked on at a time.
//   The config channel writes duration_minutes; it is ready whenever reset
//   is released. It must be written only while the block is idle; the block
//   itself does not enforce this.
//   Reset empties the table (fill count only, no memory sweep), zeroes the
//   duration and holds both slave sides off. A stalled receiver holds the
//   result in the output register while further commands are still taken;
//   a second query that finishes meanwhile waits in its emit state, with
//   the slave stream held off, until the register frees up.
// ----------------------------------------------------------------------------
module daily_schedule_next_occurrence_top #(
    parameter int MAX_ENTRIES = dsno_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config: duration_minutes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dsno_pkg::DUR_W-1:0]        i_cfg_data,
    // [1:0] func, [15:2] start_minute, [32:16] now_second, [39:33] zero
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [dsno_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // [0] active, [17:1] seconds_until, [34:18] seconds_remaining,
    // [52:35] start_second, [55:53] zero
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [dsno_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = dsno_pkg::SEC_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [SW-1:0]        r_dur_s;
    logic [SW-1:0]        r_now;
    logic [CW-1:0]        r_idx;
    logic                 r_active;
    logic                 r_found;
    logic [SW-1:0]        r_best;
    logic [SW-1:0]        r_best_start;
    logic [SW-1:0]        r_remain;
    logic                 r_m_valid;
    logic [dsno_pkg::OUT_DATA_W-1:0] r_m_data;

    dsno_pkg::t_tbl_cmd   w_cmd;
    logic [SW-1:0]        w_rd_data;
    logic [CW-1:0]        w_count;
    logic                 w_accept;
    logic [dsno_pkg::FUNC_W-1:0] w_func;
    logic [dsno_pkg::MIN_W-1:0]  w_start_min;
    logic [SW-1:0]        w_now_raw;
    logic [SW-1:0]        w_now;
    logic [SW-1:0]        w_elapsed;
    logic [SW-1:0]        w_until;
    logic                 w_hit;
    logic                 w_out_free;
    logic [SW-1:0]        w_res_until;
    logic [SW-1:0]        w_res_remain;
    logic [SW:0]          w_res_start;

    assign o_cfg_ready     = i_rst_n;
    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_func      = i_s_axis_tdata[1:0];
    assign w_start_min = i_s_axis_tdata[15:2];
    assign w_now_raw   = i_s_axis_tdata[32:16];
    assign w_now       = (w_now_raw >= dsno_pkg::SEC_PER_DAY) ?
                         w_now_raw - dsno_pkg::SEC_PER_DAY : w_now_raw;

    assign w_cmd.clr       = w_accept && (w_func == dsno_pkg::FUNC_CLEAR);
    assign w_cmd.wr        = w_accept && (w_func == dsno_pkg::FUNC_APPEND);
    assign w_cmd.wr_second = dsno_pkg::minute_to_second(w_start_min);

    dsno_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_rd_data),
        .o_count   (w_count)
    );

    // Distances around the day circle between the query second and the
    // entry being scanned; both stay below one day.
    always_comb begin
        if (r_now >= w_rd_data) begin
            w_elapsed = r_now - w_rd_data;
            w_until   = (r_now == w_rd_data) ? '0 :
                        dsno_pkg::SEC_PER_DAY - (r_now - w_rd_data);
        end else begin
            w_elapsed = dsno_pkg::SEC_PER_DAY - (w_rd_data - r_now);
            w_until   = w_rd_data - r_now;
        end
    end

    assign w_hit = (r_dur_s != '0) && (w_elapsed < r_dur_s);

    assign w_out_free   = !r_m_valid || i_m_axis_tready;
    assign w_res_until  = (r_found && !r_active) ? r_best : '0;
    assign w_res_remain = r_active ? r_remain : '0;
    assign w_res_start  = r_found ? {1'b0, r_best_start} : '1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur_s <= '0;
        end else if (i_cfg_valid) begin
            r_dur_s <= dsno_pkg::minutes_to_seconds(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            // the emit state drives the valid flag itself
            if (r_m_valid && i_m_axis_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_func == dsno_pkg::FUNC_QUERY)) begin
                        r_now        <= w_now;
                        r_idx        <= '0;
                        r_active     <= 1'b0;
                        r_found      <= 1'b0;
                        r_best       <= dsno_pkg::SEC_PER_DAY;
                        r_best_start <= '0;
                        r_remain     <= '0;
                        r_state      <= (w_count == '0) ? S_EMIT : S_FETCH;
                    end
                end
                S_FETCH: begin
                    // entry 0 is being read; advance the read pointer
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_active     <= 1'b1;
                        r_found      <= 1'b1;
                        r_remain     <= r_dur_s - w_elapsed;
                        r_best_start <= w_rd_data;
                        r_state      <= S_EMIT;
                    end else begin
                        if (w_until < r_best) begin
                            r_best       <= w_until;
                            r_best_start <= w_rd_data;
                            r_found      <= 1'b1;
                        end
                        // r_idx leads the entry under test by one
                        if (r_idx == w_count) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {3'b0, w_res_start, w_res_remain, w_res_until, r_active};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

>>> tb/daily_schedule_next_occurrence_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// daily_schedule_next_occurrence_top_tb
// Streams clear, append and query commands into the schedule block and checks
// every query answer against a local model of the start table. Both stream
// sides idle in random bursts outside the calm last phase; the duration
// register is rewritten between phases while the block is quiet.
// ----------------------------------------------------------------------------
module daily_schedule_next_occurrence_top_tb;

    localparam int DAY_SEC = 86400;
    localparam int DAY_MIN = 1440;
    localparam int TABLE_DEPTH = dsno_pkg::MAX_ENTRIES_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 225;
    localparam logic [dsno_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [dsno_pkg::FUNC_W-1:0] func;
        logic [dsno_pkg::MIN_W-1:0]  start_minute;
        logic [dsno_pkg::SEC_W-1:0]  now_second;
    } t_sched_cmd;

    typedef struct packed {
        logic        active;
        logic [16:0] until_s;
        logic [16:0] remain_s;
        logic [17:0] start_s;
    } t_occurrence;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [dsno_pkg::DUR_W-1:0]        i_cfg_data = '0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [dsno_pkg::IN_DATA_W-1:0]    i_s_axis_tdata = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [dsno_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata;

    // model of the block
    int                         day_starts [TABLE_DEPTH];
    int                         entry_total = 0;
    logic [dsno_pkg::DUR_W-1:0] dur_minutes = '0;

    t_sched_cmd  cmd_queue [$];
    t_occurrence pending_answers [$];
    int          gen_starts [$];   // start seconds queued since the last clear (hints only)

    t_sched_cmd  cur_cmd;
    bit          cmd_taken = 1'b0;
    bit          calm = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          phase;
    int          phase_dur [8];
    t_occurrence want;
    t_occurrence got;

    daily_schedule_next_occurrence_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("daily_schedule_next_occurrence_top_tb: FAIL");
            $finish;
        end
    end

    // First covering window wins; otherwise the nearest start, earliest entry on a tie.
    function automatic t_occurrence next_occurrence(input logic [16:0] now_raw);
        int          now;
        int          dur_s;
        int          elapsed;
        int          wait_s;
        int          best;
        int          idx;
        t_occurrence r;
        now = int'(now_raw) % DAY_SEC;
        dur_s = int'(dur_minutes) * 60;
        best = DAY_SEC;
        r = '0;
        r.start_s = '1;
        for (idx = 0; idx < entry_total; idx++) begin
            elapsed = (now + DAY_SEC - day_starts[idx]) % DAY_SEC;
            wait_s = (day_starts[idx] + DAY_SEC - now) % DAY_SEC;
            if (dur_s > 0 && elapsed < dur_s) begin
                r.active = 1'b1;
                r.until_s = '0;
                r.remain_s = 17'(dur_s - elapsed);
                r.start_s = 18'(day_starts[idx]);
                return r;
            end
            if (wait_s < best) begin
                best = wait_s;
                r.until_s = 17'(wait_s);
                r.start_s = 18'(day_starts[idx]);
            end
        end
        return r;
    endfunction

    // Input side: update the model on each accepted transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin : accept_cmd
            int mins;
            cmd_taken = 1'b1;
            case (cur_cmd.func)
                dsno_pkg::FUNC_CLEAR: entry_total = 0;
                dsno_pkg::FUNC_APPEND: begin
                    if (entry_total < TABLE_DEPTH) begin
                        mins = int'($signed(cur_cmd.start_minute)) % DAY_MIN;
                        if (mins < 0) mins += DAY_MIN;
                        day_starts[entry_total] = mins * 60;
                        entry_total++;
                    end
                end
                dsno_pkg::FUNC_QUERY: begin
                    pending_answers = {pending_answers, next_occurrence(cur_cmd.now_second)};
                end
                default: ;
            endcase
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 12) - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                cur_cmd = cmd_queue.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {{(dsno_pkg::IN_DATA_W - 33){1'b0}}, cur_cmd.now_second,
                                   cur_cmd.start_minute, cur_cmd.func};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: stall in bursts, compare each answer with the oldest prediction.
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            i_m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 12) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.active = o_m_axis_tdata[0];
            got.until_s = o_m_axis_tdata[17:1];
            got.remain_s = o_m_axis_tdata[34:18];
            got.start_s = o_m_axis_tdata[52:35];
            if (pending_answers.size() == 0) begin
                $display("%0t: answer expected none got %h", $time, o_m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (got.active !== want.active) begin
                    $display("%0t: active expected %0d got %0d", $time, want.active,
                             got.active);
                    mismatches++;
                end
                if (got.until_s !== want.until_s) begin
                    $display("%0t: seconds_until expected %0d got %0d", $time, want.until_s,
                             got.until_s);
                    mismatches++;
                end
                if (got.remain_s !== want.remain_s) begin
                    $display("%0t: seconds_remaining expected %0d got %0d", $time,
                             want.remain_s, got.remain_s);
                    mismatches++;
                end
                if (got.start_s !== want.start_s) begin
                    $display("%0t: start_second expected %0d got %0d", $time,
                             $signed(want.start_s), $signed(got.start_s));
                    mismatches++;
                end
                if (o_m_axis_tdata[55:53] !== 3'b000) begin
                    $display("%0t: tdata padding expected 0 got %b", $time,
                             o_m_axis_tdata[55:53]);
                    mismatches++;
                end
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] f, input logic [13:0] sm, input logic [16:0] ns);
        t_sched_cmd c;
        c.func = f;
        c.start_minute = sm;
        c.now_second = ns;
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || i_s_axis_tvalid || pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_duration(input int d);
        wait_drained();
        // let a trailing append or clear settle inside the block
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= 11'(d);
        do @(posedge i_clk); while (!o_cfg_ready);
        dur_minutes = 11'(d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly clear / append / query runs with random content, some noise.
    task automatic build_random(input int n);
        int made;
        int k;
        int q;
        int i;
        int s;
        int wrap;
        int off;
        int now;
        int dur_s;
        int pick;
        made = 0;
        dur_s = int'(dur_minutes) * 60;
        while (made < n) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                queue_cmd(FUNC_NONE, 14'($urandom), 17'($urandom));
            end else if (pick <= 7) begin
                if ($urandom_range(0, 3) != 0) begin
                    queue_cmd(dsno_pkg::FUNC_CLEAR, 14'($urandom), 17'($urandom));
                    gen_starts.delete();
                    made++;
                end
                k = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
                for (i = 0; i < k; i++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        queue_cmd(dsno_pkg::FUNC_APPEND, 14'($urandom), 17'($urandom));
                    end else begin
                        s = $urandom_range(0, DAY_MIN - 1);
                        wrap = $urandom_range(0, 9);
                        queue_cmd(dsno_pkg::FUNC_APPEND, 14'(s + DAY_MIN * (wrap - 5)),
                                  17'($urandom));
                        gen_starts = {gen_starts, s * 60};
                    end
                    made++;
                end
                q = $urandom_range(1, 6);
                for (i = 0; i < q; i++) begin
                    if (gen_starts.size() == 0 || $urandom_range(0, 4) == 0) begin
                        now = $urandom_range(0, 131071);
                    end else begin
                        s = gen_starts[$urandom_range(0, gen_starts.size() - 1)];
                        case ($urandom_range(0, 4))
                            0: off = 0;
                            1: off = dur_s - 1;
                            2: off = dur_s;
                            3: off = DAY_SEC - 1;
                            default: off = $urandom_range(0, dur_s + 600);
                        endcase
                        now = (s + off + 2 * DAY_SEC) % DAY_SEC;
                        if (now < 131072 - DAY_SEC && $urandom_range(0, 7) == 0) now += DAY_SEC;
                    end
                    queue_cmd(dsno_pkg::FUNC_QUERY, 14'($urandom), 17'(now));
                    made++;
                end
            end else begin
                k = $urandom_range(1, 4);
                for (i = 0; i < k; i++) begin
                    queue_cmd(2'($urandom_range(0, 2)), 14'($urandom), 17'($urandom));
                    made++;
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-hour windows, boundary minutes and seconds
        write_duration(60);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd0);
        queue_cmd(FUNC_NONE, 14'h3FFF, 17'h1FFFF);
        queue_cmd(dsno_pkg::FUNC_APPEND, 14'h2000, 17'd0);   // most negative minute
        queue_cmd(dsno_pkg::FUNC_APPEND, 14'sd8191, 17'd0);
        queue_cmd(dsno_pkg::FUNC_APPEND, 14'sd0, 17'd0);
        queue_cmd(dsno_pkg::FUNC_APPEND, 14'sd1439, 17'd0);
        queue_cmd(dsno_pkg::FUNC_APPEND, 14'sd1440, 17'd0);
        queue_cmd(dsno_pkg::FUNC_APPEND, -14'sd1, 17'd0);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd0);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd86399);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd86400);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd131071);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd30479);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd30480);
        queue_cmd(dsno_pkg::FUNC_CLEAR, 14'd0, 17'd0);
        queue_cmd(dsno_pkg::FUNC_QUERY, 14'd0, 17'd5000);

        phase_dur = '{0, DAY_MIN, 2047, 1, DAY_MIN + 1, 0, 0, 720};
        phase_dur[5] = $urandom_range(0, 2047);
        phase_dur[6] = $urandom_range(2, DAY_MIN - 1);
        for (phase = 0; phase < 8; phase++) begin
            write_duration(phase_dur[phase]);
            if (phase == 7) calm = 1'b1;
            build_random(PHASE_ITEMS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("daily_schedule_next_occurrence_top_tb: PASS");
        end else begin
            $display("daily_schedule_next_occurrence_top_tb: FAIL");
        end
        $finish;
    end

endmodule
